// ----- rtl/fwbc_pkg.sv -----
// Shared constants, codes and types of the FIFO write-back cluster cache.
// No dependencies; imported by fwbc_seq, the top-level core and the testbench.
package fwbc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_WIDTH  = 64;

  localparam int WORD_W = 64;
  localparam int TAG_W  = 32;
  localparam int SIZE_W = 13;
  localparam int BPC_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W + BPC_W > SIZE_W) ? CNT_W + BPC_W : SIZE_W;

  // Shift by the full word width gives zero, so the mask is all ones then.
  localparam logic [WORD_W-1:0] DATA_MASK = (WORD_W'(1) << DATA_WIDTH) - WORD_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);
  localparam logic [BPC_W-1:0]  BPC_RESET  = BPC_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_CAP_BLOCKS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_RDREQ = 2'd1,
    KIND_WRREQ = 2'd2
  } kind_t;

  typedef struct packed {
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } ram_wr_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [WORD_W-1:0] data;
    logic              last;
  } result_t;

endpackage

// ----- rtl/fwbc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fwbc_seq.sv -----
// Sequencer of the cluster cache: scan, compaction, append, eviction, flush.
// Depends on fwbc_pkg; drives the entry RAM ports and the result word.
module fwbc_seq import fwbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [1:0]        mode_in,
  input  logic [TAG_W-1:0]  tag_in,
  input  logic [WORD_W-1:0] data_in,
  input  logic [SIZE_W-1:0] cap_blocks,
  input  logic [BPC_W-1:0]  bpc,
  input  entry_t            rd_data,
  output ram_rd_t           rd,
  output ram_wr_t           wr,
  output result_t           res,
  output logic              busy
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SCAN   = 10'b00_0000_0010,
    S_SH_RD  = 10'b00_0000_0100,
    S_SH_WR  = 10'b00_0000_1000,
    S_APPEND = 10'b00_0001_0000,
    S_EV_RD  = 10'b00_0010_0000,
    S_EV_CHK = 10'b00_0100_0000,
    S_EV_WB  = 10'b00_1000_0000,
    S_FL_RD  = 10'b01_0000_0000,
    S_FL_CHK = 10'b10_0000_0000
  } state_t;

  // Logical queue position to RAM slot, ring starting at head.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] lidx);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + (IDX_W+1)'(lidx);
    if (sum >= (IDX_W+1)'(MAX_ENTRIES)) begin
      sum = sum - (IDX_W+1)'(MAX_ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic result_t mk_res(input kind_t k, input logic [TAG_W-1:0] t,
                                     input logic [WORD_W-1:0] d, input logic l);
    result_t r;
    r.vld  = 1'b1;
    r.kind = k;
    r.tag  = t;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  cmp_idx;
  logic              cmp_vld;
  logic [CNT_W-1:0]  k;
  mode_t             mode_q;
  logic [TAG_W-1:0]  tag_q;
  logic [WORD_W-1:0] data_q;
  logic              over_q;
  logic              pend_vld;
  logic [TAG_W-1:0]  pend_tag;
  logic [WORD_W-1:0] pend_data;

  mode_t             mode_i;
  logic [WORD_W-1:0] data_m;
  logic              enabled;
  logic              issue_more;
  logic              hit;
  logic              scan_miss;
  logic [CNT_W-1:0]  k_inc;
  logic              sh_more;
  logic              fl_more;
  logic [CNT_W-1:0]  count_inc;
  logic              over_now;
  logic [CMP_W-1:0]  prod;
  logic              evict_now;
  logic [IDX_W-1:0]  head_inc;

  assign mode_i     = mode_t'(mode_in);
  assign data_m     = data_in & DATA_MASK;
  assign enabled    = cap_blocks != '0;
  assign issue_more = scan_idx < count;
  assign hit        = cmp_vld && (rd_data.tag == tag_q);
  assign scan_miss  = !cmp_vld && !issue_more;
  assign k_inc      = k + CNT_W'(1);
  assign sh_more    = k_inc < count;
  assign fl_more    = k < count;
  assign count_inc  = count + CNT_W'(1);
  assign over_now   = count >= CNT_W'(MAX_ENTRIES);
  assign prod       = CMP_W'(count_inc) * CMP_W'(bpc);
  assign evict_now  = over_now || (prod > CMP_W'(cap_blocks));
  assign head_inc   = (head == IDX_W'(MAX_ENTRIES - 1)) ? '0 : head + IDX_W'(1);
  assign busy       = state != S_IDLE;

  always_comb begin
    rd  = '0;
    wr  = '0;
    res = '0;
    unique case (state)
      S_IDLE: begin
        if (go && !enabled) begin
          unique case (mode_i)
            MODE_READ:  res = mk_res(KIND_RDREQ, tag_in, '0, 1'b1);
            MODE_FILL:  res = mk_res(KIND_DATA, tag_in, data_m, 1'b1);
            MODE_WRITE: res = mk_res(KIND_WRREQ, tag_in, data_m, 1'b1);
            MODE_FLUSH: res = '0;
          endcase
        end
      end
      S_SCAN: begin
        rd.re   = issue_more;
        rd.addr = phys(head, scan_idx);
        if (hit) begin
          if (mode_q == MODE_READ) begin
            res = mk_res(KIND_DATA, tag_q, rd_data.data, 1'b1);
          end else if (mode_q == MODE_FILL) begin
            res = mk_res(KIND_DATA, tag_q, data_q, 1'b1);
          end
        end else if (scan_miss && mode_q == MODE_READ) begin
          res = mk_res(KIND_RDREQ, tag_q, '0, 1'b1);
        end
      end
      S_SH_RD: begin
        rd.re   = sh_more;
        rd.addr = phys(head, k_inc);
      end
      S_SH_WR: begin
        wr.we    = 1'b1;
        wr.addr  = phys(head, k);
        wr.entry = rd_data;
      end
      S_APPEND: begin
        if (!over_now) begin
          wr.we          = 1'b1;
          wr.addr        = phys(head, count);
          wr.entry.dirty = mode_q == MODE_WRITE;
          wr.entry.tag   = tag_q;
          wr.entry.data  = data_q;
        end
        if (!evict_now && mode_q == MODE_FILL) begin
          res = mk_res(KIND_DATA, tag_q, data_q, 1'b1);
        end
      end
      S_EV_RD: begin
        rd.re   = 1'b1;
        rd.addr = head;
      end
      S_EV_CHK: begin
        // Full queue: the new entry takes the slot the oldest one leaves.
        if (over_q) begin
          wr.we          = 1'b1;
          wr.addr        = head;
          wr.entry.dirty = mode_q == MODE_WRITE;
          wr.entry.tag   = tag_q;
          wr.entry.data  = data_q;
        end
        if (mode_q == MODE_FILL) begin
          res = mk_res(KIND_DATA, tag_q, data_q, !rd_data.dirty);
        end else if (rd_data.dirty) begin
          res = mk_res(KIND_WRREQ, rd_data.tag, rd_data.data, 1'b1);
        end
      end
      S_EV_WB: begin
        res = mk_res(KIND_WRREQ, pend_tag, pend_data, 1'b1);
      end
      S_FL_RD: begin
        rd.re   = fl_more;
        rd.addr = phys(head, k);
        if (!fl_more && pend_vld) begin
          res = mk_res(KIND_WRREQ, pend_tag, pend_data, 1'b1);
        end
      end
      S_FL_CHK: begin
        if (rd_data.dirty) begin
          wr.we          = 1'b1;
          wr.addr        = phys(head, k);
          wr.entry.dirty = 1'b0;
          wr.entry.tag   = rd_data.tag;
          wr.entry.data  = rd_data.data;
          if (pend_vld) begin
            res = mk_res(KIND_WRREQ, pend_tag, pend_data, 1'b0);
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      cmp_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            mode_q   <= mode_i;
            tag_q    <= tag_in;
            data_q   <= data_m;
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            k        <= '0;
            pend_vld <= 1'b0;
            if (mode_i == MODE_FLUSH) begin
              state <= S_FL_RD;
            end else if (enabled) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (mode_q == MODE_WRITE) begin
              k     <= cmp_idx;
              state <= S_SH_RD;
            end else begin
              state <= S_IDLE;
            end
          end else if (scan_miss) begin
            state <= (mode_q == MODE_READ) ? S_IDLE : S_APPEND;
          end else begin
            cmp_vld <= issue_more;
            cmp_idx <= scan_idx;
            if (issue_more) begin
              scan_idx <= scan_idx + CNT_W'(1);
            end
          end
        end
        S_SH_RD: begin
          if (sh_more) begin
            state <= S_SH_WR;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_APPEND;
          end
        end
        S_SH_WR: begin
          k     <= k_inc;
          state <= S_SH_RD;
        end
        S_APPEND: begin
          over_q <= over_now;
          if (!over_now) begin
            count <= count_inc;
          end
          state <= evict_now ? S_EV_RD : S_IDLE;
        end
        S_EV_RD: begin
          state <= S_EV_CHK;
        end
        S_EV_CHK: begin
          head <= head_inc;
          if (!over_q) begin
            count <= count - CNT_W'(1);
          end
          if (mode_q == MODE_FILL && rd_data.dirty) begin
            pend_tag  <= rd_data.tag;
            pend_data <= rd_data.data;
            state     <= S_EV_WB;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EV_WB: begin
          state <= S_IDLE;
        end
        S_FL_RD: begin
          state <= fl_more ? S_FL_CHK : S_IDLE;
        end
        S_FL_CHK: begin
          if (rd_data.dirty) begin
            pend_vld  <= 1'b1;
            pend_tag  <= rd_data.tag;
            pend_data <= rd_data.data;
          end
          k     <= k_inc;
          state <= S_FL_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/fifo_write_back_cluster_cache_core.sv -----
// Top level of the FIFO write-back cluster cache: config registers, entry RAM,
// sequencer and result register. Depends on fwbc_pkg, fwbc_ram, fwbc_seq.
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  --------------------------
//  command   mode, cluster_number, data_word            start & !busy takes a word
//  result    kind, cluster_id, data_out, last           result_valid, one cycle
//  config    cfg_index, cfg_data                        cfg_we, one cycle, no wait
//
// Each command is one word. Read, fill and write walk the queue one entry
// per cycle, and a hit ends the lookup early; a fill or write miss then
// appends and, when the queue is full or over capacity, evicts the oldest
// entry (a fill with a dirty victim gives its write-back after the read data).
// A write hit first compacts the queue behind the hit entry, then appends.
// Flush reads each entry in turn and writes back the dirty ones. The single
// RAM read port sets this pacing. With caching disabled a read, fill or
// write finishes in the cycle it is taken.
// Reset: control state clears and the queue starts empty; the RAM needs
// no clearing pass. Results sit on the ports for one cycle after the
// register stage; the receiver cannot stall, so nothing holds them.
module fifo_write_back_cluster_cache_core import fwbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [TAG_W-1:0]     cluster_number,
  input  logic [WORD_W-1:0]    data_word,
  output logic                 result_valid,
  output logic [1:0]           kind,
  output logic [TAG_W-1:0]     cluster_id,
  output logic [WORD_W-1:0]    data_out,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0]  cap_blocks;
  logic [BPC_W-1:0]   bpc;
  logic               go;
  ram_rd_t            rd;
  ram_wr_t            wr;
  result_t            res;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  // A command word is taken only between operations.
  assign go       = start && !busy;
  assign rd_entry = ram_rdata;

  // Config registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_blocks <= SIZE_RESET;
      bpc        <= BPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAP_BLOCKS:     cap_blocks <= cfg_data;
        REG_CLUSTER_BLOCKS: bpc        <= cfg_data[BPC_W-1:0];
      endcase
    end
  end

  // Entry queue storage: dirty mark, tag and data word per slot.
  fwbc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.entry),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  fwbc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .mode_in    (mode),
    .tag_in     (cluster_number),
    .data_in    (data_word),
    .cap_blocks (cap_blocks),
    .bpc        (bpc),
    .rd_data    (rd_entry),
    .rd         (rd),
    .wr         (wr),
    .res        (res),
    .busy       (busy)
  );

  // Result register: strobe resets, payload follows every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    kind       <= res.kind;
    cluster_id <= res.tag;
    data_out   <= res.data;
    last       <= res.last;
  end

endmodule

// ----- tb/sv/tb_fifo_write_back_cluster_cache_core.sv -----
`timescale 1ns / 1ps
// Testbench for fifo_write_back_cluster_cache_core: a directed table, then random
// traffic over several capacity settings, every result word checked in order.
// Depends on fwbc_pkg and the core RTL.
module tb_fifo_write_back_cluster_cache_core;
  import fwbc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 10;
  // Longest busy stretch of one word: a write hit at the queue head compacts
  // the whole queue, a flush reads and checks each entry in turn.
  localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 43;
  localparam int TAG_POOL      = 20;
  localparam int MAX_REPORTS   = 60;

  // One result word as the block presents it.
  typedef struct packed {
    kind_t             kind;
    logic [TAG_W-1:0]  id;
    logic [WORD_W-1:0] data;
    logic              last;
  } cache_word_t;

  // One row of the directed table: either a register write or a command word,
  // the latter optionally with its single result typed in.
  typedef struct {
    bit                   reg_write;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [SIZE_W-1:0]    reg_val;
    mode_t                op;
    logic [TAG_W-1:0]     tag;
    logic [WORD_W-1:0]    word;
    bit                   typed;
    kind_t                want_kind;
    logic [WORD_W-1:0]    want_data;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           mode;
  logic [TAG_W-1:0]     cluster_number;
  logic [WORD_W-1:0]    data_word;
  logic                 result_valid;
  logic [1:0]           kind;
  logic [TAG_W-1:0]     cluster_id;
  logic [WORD_W-1:0]    data_out;
  logic                 last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  fifo_write_back_cluster_cache_core uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .cluster_number (cluster_number),
    .data_word      (data_word),
    .result_valid   (result_valid),
    .kind           (kind),
    .cluster_id     (cluster_id),
    .data_out       (data_out),
    .last           (last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Mirror of the cache: capacity registers and the FIFO of entries, oldest
  // at index 0.
  logic [SIZE_W-1:0] mir_size;
  logic [BPC_W-1:0]  mir_bpc;
  logic [TAG_W-1:0]  mir_tag   [MAX_ENTRIES];
  logic [WORD_W-1:0] mir_data  [MAX_ENTRIES];
  logic              mir_dirty [MAX_ENTRIES];
  int                mir_count;

  cache_word_t      step_words[$];     // results of the word just taken
  cache_word_t      pending_words[$];  // results still owed by the block, oldest first
  cache_word_t      head_word;
  logic [TAG_W-1:0] missed_tags[$];    // read misses waiting for their fill
  logic [TAG_W-1:0] tag_pool [TAG_POOL];
  plan_row_t        directed_plan[$];
  int               mismatches  = 0;
  int               cycle_count = 0;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mirror of the cache behavior
  // ---------------------------------------------------------------------------

  function automatic int mirror_find(logic [TAG_W-1:0] tag);
    for (int i = 0; i < mir_count; i++)
      if (mir_tag[i] == tag) return i;
    return -1;
  endfunction

  // Drop one entry and close the gap, keeping FIFO order.
  function automatic void mirror_remove(int pos);
    for (int i = pos; i + 1 < mir_count; i++) begin
      mir_tag[i]   = mir_tag[i + 1];
      mir_data[i]  = mir_data[i + 1];
      mir_dirty[i] = mir_dirty[i + 1];
    end
    mir_count--;
  endfunction

  // Append at the tail. At most one eviction follows: the head goes when the
  // queue is full or entries times the cluster size in blocks exceeds the
  // capacity, and it is written back only if dirty. A full queue takes the
  // new entry after the head is gone.
  function automatic void mirror_append(logic [TAG_W-1:0] tag, logic [WORD_W-1:0] word,
                                        logic dirty);
    bit full;
    full = (mir_count >= MAX_ENTRIES);
    if (!full) begin
      mir_tag[mir_count]   = tag;
      mir_data[mir_count]  = word;
      mir_dirty[mir_count] = dirty;
      mir_count++;
    end
    if (full || mir_count * int'(mir_bpc) > int'(mir_size)) begin
      if (mir_dirty[0])
        step_words.push_back(cache_word_t'{KIND_WRREQ, mir_tag[0], mir_data[0], 1'b0});
      mirror_remove(0);
      if (full) begin
        mir_tag[mir_count]   = tag;
        mir_data[mir_count]  = word;
        mir_dirty[mir_count] = dirty;
        mir_count++;
      end
    end
  endfunction

  // Work out the results of one command word into step_words and update the
  // mirror. A capacity of zero bypasses the queue for read, fill and write.
  function automatic void cache_predict(mode_t op, logic [TAG_W-1:0] tag,
                                        logic [WORD_W-1:0] word);
    int pos;
    bit caching;
    logic [WORD_W-1:0] value;
    step_words.delete();
    caching = (mir_size != '0);
    value   = word & DATA_MASK;
    case (op)
      MODE_READ: begin
        pos = caching ? mirror_find(tag) : -1;
        if (pos >= 0)
          step_words.push_back(cache_word_t'{KIND_DATA, tag, mir_data[pos], 1'b0});
        else
          step_words.push_back(cache_word_t'{KIND_RDREQ, tag, '0, 1'b0});
      end
      MODE_FILL: begin
        // the disk data always goes back; a cluster already cached is left alone
        step_words.push_back(cache_word_t'{KIND_DATA, tag, value, 1'b0});
        if (caching && mirror_find(tag) < 0) mirror_append(tag, value, 1'b0);
      end
      MODE_WRITE: begin
        if (caching) begin
          pos = mirror_find(tag);
          if (pos >= 0) mirror_remove(pos);
          mirror_append(tag, value, 1'b1);
        end else begin
          step_words.push_back(cache_word_t'{KIND_WRREQ, tag, value, 1'b0});
        end
      end
      default: begin
        // flush runs whatever the capacity, oldest dirty entry first
        for (int i = 0; i < mir_count; i++) begin
          if (mir_dirty[i]) begin
            step_words.push_back(cache_word_t'{KIND_WRREQ, mir_tag[i], mir_data[i], 1'b0});
            mir_dirty[i] = 1'b0;
          end
        end
      end
    endcase
    if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cmd_row(mode_t op, logic [TAG_W-1:0] tag,
                                        logic [WORD_W-1:0] word);
    plan_row_t r;
    r.reg_write = 1'b0;
    r.reg_sel   = REG_CAP_BLOCKS;
    r.reg_val   = '0;
    r.op        = op;
    r.tag       = tag;
    r.word      = word;
    r.typed     = 1'b0;
    r.want_kind = KIND_DATA;
    r.want_data = '0;
    return r;
  endfunction

  // Command whose single result is plain from the current state.
  function automatic plan_row_t typed_row(mode_t op, logic [TAG_W-1:0] tag,
                                          logic [WORD_W-1:0] word, kind_t want_kind,
                                          logic [WORD_W-1:0] want_data);
    plan_row_t r;
    r = cmd_row(op, tag, word);
    r.typed     = 1'b1;
    r.want_kind = want_kind;
    r.want_data = want_data;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] sel, logic [SIZE_W-1:0] val);
    plan_row_t r;
    r = cmd_row(MODE_READ, '0, '0);
    r.reg_write = 1'b1;
    r.reg_sel   = sel;
    r.reg_val   = val;
    return r;
  endfunction

  // Mostly a small pool so that hits, write hits and evictions are common.
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return tag_pool[$urandom_range(0, TAG_POOL - 1)];
  endfunction

  function automatic logic [WORD_W-1:0] pick_data();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Called at a falling edge; returns at a falling edge with cfg_we low.
  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (sel == REG_CAP_BLOCKS) mir_size = val;
    else mir_bpc = val[BPC_W-1:0];
  endtask

  // Hold off until every owed word has arrived and the block has gone quiet;
  // a word with no result can keep it busy after the last one came out.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Present one command word at a falling edge and hold it until the block
  // takes it. start is left high so a following word can go out back to back.
  task automatic send_word(mode_t op, logic [TAG_W-1:0] tag, logic [WORD_W-1:0] word,
                           bit typed, kind_t want_kind, logic [WORD_W-1:0] want_data);
    start          <= 1'b1;
    mode           <= op;
    cluster_number <= tag;
    data_word      <= word;
    do @(posedge clk); while (busy);
    cache_predict(op, tag, word);
    if (typed) begin
      step_words.delete();
      step_words.push_back(cache_word_t'{want_kind, tag, want_data, 1'b1});
    end
    if (op == MODE_READ && step_words[0].kind == KIND_RDREQ) begin
      missed_tags.push_back(tag);
      if (missed_tags.size() > 4) void'(missed_tags.pop_front());
    end
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every strobed word against the oldest owed one
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t ns: word with none owed, expected nothing, ",
                    "got kind %0d id %h data %h last %b"},
                   $time, kind, cluster_id, data_out, last);
      end else begin
        head_word = pending_words.pop_front();
        check_field("kind", WORD_W'(head_word.kind), WORD_W'(kind));
        check_field("cluster_id", WORD_W'(head_word.id), WORD_W'(cluster_id));
        check_field("data_out", head_word.data, data_out);
        check_field("last", WORD_W'(head_word.last), WORD_W'(last));
      end
    end
  end

  // Watchdog: a lost result or a stuck busy ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_size [PHASES];
    logic [BPC_W-1:0]  phase_bpc  [PHASES];
    int                roll;
    mode_t             op;
    logic [TAG_W-1:0]  tag;
    bit                idling;

    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_READ;
    cluster_number = '0;
    data_word      = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CAP_BLOCKS;
    cfg_data       = '0;

    mir_size  = SIZE_RESET;
    mir_bpc   = BPC_RESET;
    mir_count = 0;
    foreach (mir_dirty[i]) begin
      mir_tag[i]   = '0;
      mir_data[i]  = '0;
      mir_dirty[i] = 1'b0;
    end

    // the all-zero and all-one tags make sure every tag bit toggles
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = $urandom;

    // Directed table. Reset capacity is 128 blocks at 8 per cluster, 16 entries.
    directed_plan.push_back(typed_row(MODE_READ, '0, '0, KIND_RDREQ, '0));   // empty cache
    directed_plan.push_back(typed_row(MODE_FILL, '0, '1, KIND_DATA, '1));
    directed_plan.push_back(typed_row(MODE_READ, '0, '0, KIND_DATA, '1));    // hit
    directed_plan.push_back(cmd_row(MODE_WRITE, '1, '0));                    // no write-back
    directed_plan.push_back(cmd_row(MODE_READ, '1, '1));
    directed_plan.push_back(cmd_row(MODE_WRITE, '1, 64'hA5A5_A5A5_A5A5_A5A5)); // hit at tail
    directed_plan.push_back(cmd_row(MODE_WRITE, '0, 64'h5A5A_5A5A_5A5A_5A5A)); // hit at head
    directed_plan.push_back(typed_row(MODE_FILL, '0, 64'h0123_4567_89AB_CDEF, KIND_DATA,
                                      64'h0123_4567_89AB_CDEF));             // already cached
    directed_plan.push_back(cmd_row(MODE_FLUSH, '0, '0));                    // both dirty
    directed_plan.push_back(cmd_row(MODE_FLUSH, '1, '1));                    // nothing dirty
    // two entries: clean then dirty victims
    directed_plan.push_back(reg_row(REG_CAP_BLOCKS, SIZE_W'(16)));
    directed_plan.push_back(cmd_row(MODE_WRITE, 32'd7, 64'h7777));
    directed_plan.push_back(cmd_row(MODE_WRITE, 32'd9, 64'h9999));
    directed_plan.push_back(cmd_row(MODE_WRITE, 32'd11, 64'hBBBB));
    // a cluster larger than the cache: every append evicts
    directed_plan.push_back(reg_row(REG_CAP_BLOCKS, SIZE_W'(63)));
    directed_plan.push_back(reg_row(REG_CLUSTER_BLOCKS, SIZE_W'(64)));
    directed_plan.push_back(cmd_row(MODE_WRITE, 32'd3, 64'h3333));
    directed_plan.push_back(cmd_row(MODE_FILL, 32'd5, 64'h5555));
    // caching off: straight to disk, queue untouched, flush still drains
    directed_plan.push_back(reg_row(REG_CAP_BLOCKS, '0));
    directed_plan.push_back(typed_row(MODE_READ, 32'd5, '0, KIND_RDREQ, '0));
    directed_plan.push_back(typed_row(MODE_WRITE, 32'd5, 64'hDEAD_BEEF, KIND_WRREQ,
                                      64'hDEAD_BEEF));
    directed_plan.push_back(typed_row(MODE_FILL, 32'd5, 64'hFEED, KIND_DATA, 64'hFEED));
    directed_plan.push_back(cmd_row(MODE_FLUSH, '0, '0));
    // capacity 4096, zero blocks per cluster: only the entry limit applies
    directed_plan.push_back(reg_row(REG_CAP_BLOCKS, SIZE_W'(4096)));
    directed_plan.push_back(reg_row(REG_CLUSTER_BLOCKS, '0));
    directed_plan.push_back(cmd_row(MODE_WRITE, 32'h1234_5678, 64'h1111_2222_3333_4444));
    directed_plan.push_back(cmd_row(MODE_READ, 32'h1234_5678, '0));
    directed_plan.push_back(reg_row(REG_CLUSTER_BLOCKS, SIZE_W'(64)));
    directed_plan.push_back(cmd_row(MODE_FLUSH, '0, '0));

    // Random phases: tight queues, one entry, self-evicting, disabled, and
    // capacities well past the entry limit (0xF0F lights the middle bits).
    phase_size = '{SIZE_W'(24), SIZE_W'(4096), SIZE_W'(1), SIZE_W'(63), SIZE_W'(0),
                   SIZE_W'(3855), SIZE_W'(128), SIZE_W'(5), SIZE_W'(0), SIZE_W'(0)};
    phase_bpc  = '{BPC_W'(8), BPC_W'(1), BPC_W'(1), BPC_W'(64), BPC_W'(8),
                   BPC_W'(3), BPC_W'(8), BPC_W'(2), BPC_W'(0), BPC_W'(0)};
    phase_size[8] = SIZE_W'($urandom_range(0, 200));
    phase_bpc[8]  = BPC_W'($urandom_range(1, 16));
    phase_size[9] = SIZE_W'($urandom_range(8, 200));
    phase_bpc[9]  = BPC_W'($urandom_range(1, 16));

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].reg_write) begin
        wait_idle();
        write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_val);
      end else begin
        send_word(directed_plan[i].op, directed_plan[i].tag, directed_plan[i].word,
                  directed_plan[i].typed, directed_plan[i].want_kind,
                  directed_plan[i].want_data);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_CAP_BLOCKS, phase_size[p]);
      write_reg(REG_CLUSTER_BLOCKS, SIZE_W'(phase_bpc[p]));
      missed_tags.delete();
      // every third phase and the last one run back to back
      idling = (p < PHASES - 1) && (p % 3 != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        tag  = pick_tag();
        roll = $urandom_range(0, 99);
        // a read miss is usually answered by its fill; stray fills are noise
        if (missed_tags.size() != 0 && roll < 40) begin
          op  = MODE_FILL;
          tag = missed_tags.pop_front();
        end else if (roll < 65) begin
          op = MODE_READ;
        end else if (roll < 72) begin
          op = MODE_FILL;
        end else if (roll < 93) begin
          op = MODE_WRITE;
        end else begin
          op = MODE_FLUSH;
        end
        send_word(op, tag, pick_data(), 1'b0, KIND_DATA, '0);
        if (idling && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 17)) @(negedge clk);
        end else if (idling && $urandom_range(0, 59) == 0) begin
          wait_idle();
        end
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fwbc_pkg.sv
rtl/fwbc_ram.sv
rtl/fwbc_seq.sv
rtl/fifo_write_back_cluster_cache_core.sv
tb/sv/tb_fifo_write_back_cluster_cache_core.sv
